// ----- src/rfm_pkg.sv -----
// rfm_pkg: shared types for the running moments engine
// op codes and request/response bundles of the shared arithmetic unit,
// sequencer step codes and the saturating-sum result type; no dependencies
package rfm_pkg;

    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_DIVQ,
        AOP_SQRT
    } arith_op_t;

    typedef struct packed {
        arith_op_t   op;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  sh;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
        logic        big;
    } arith_rsp_t;

    typedef struct packed {
        logic signed [63:0] val;
        logic               sat;
    } sat64_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DK,
        ST_M1,
        ST_T40,
        ST_TERM,
        ST_POLY,
        ST_RR,
        ST_SS,
        ST_A4,
        ST_X,
        ST_Y,
        ST_B4,
        ST_Z,
        ST_C4,
        ST_W,
        ST_A3,
        ST_U,
        ST_B3,
        ST_SUM1,
        ST_SUM2,
        ST_SUM3,
        ST_VAR,
        ST_PV,
        ST_SQRT,
        ST_DEN3,
        ST_DEN4,
        ST_N3,
        ST_SKEW,
        ST_N4,
        ST_KURT,
        ST_FIN
    } step_t;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

endpackage

// ----- src/rfm_arith.sv -----
// rfm_arith: shared iterative arithmetic unit of the moments engine
// 64x64 multiply from four 32x32 partial products, restoring divide one bit
// a cycle, floor square root one result bit a cycle; uses rfm_pkg
module rfm_arith
    import rfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    localparam logic [6:0] LAST_MUL  = 7'd3;
    localparam logic [6:0] LAST_DIV  = 7'd63;
    localparam logic [6:0] LAST_DIVQ = 7'd79;
    localparam logic [6:0] LAST_SQRT = 7'd31;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    arith_op_t    op_reg, op_next;
    logic [6:0]   sh_reg, sh_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic [63:0]  z_reg, z_next;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  rr;
    logic         ge;
    logic [63:0]  tsum;
    logic [6:0]   last;
    logic [127:0] prod_sh;

    // one partial product a cycle
    assign pa = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
    assign pb = cnt_reg[1] ? z_reg[63:32] : z_reg[31:0];
    assign pp = 64'(pa) * 64'(pb);

    always_comb
    begin
        case ({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]})
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            default: pp_sh = {pp, 64'b0};
        endcase
    end

    // divide step: x holds dividend/quotient, y remainder, z divisor
    assign rr = {y_reg, x_reg[79]};
    assign ge = rr >= {1'b0, z_reg};

    // root step: y holds the remainder, x the root, z the current bit
    assign tsum = x_reg[63:0] + z_reg;

    always_comb
    begin
        case (op_reg)
            AOP_MUL:  last = LAST_MUL;
            AOP_DIV:  last = LAST_DIV;
            AOP_DIVQ: last = LAST_DIVQ;
            default:  last = LAST_SQRT;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            sh_next   = req.sh;
            cnt_next  = '0;
            case (req.op)
                AOP_MUL:
                begin
                    x_next = '0;
                    y_next = req.a;
                    z_next = req.b;
                end
                AOP_DIV, AOP_DIVQ:
                begin
                    x_next = {48'b0, req.a, 16'b0};
                    y_next = '0;
                    z_next = req.b;
                end
                default:
                begin
                    x_next = '0;
                    y_next = req.a;
                    z_next = 64'h4000_0000_0000_0000;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                AOP_MUL:
                begin
                    x_next = x_reg + pp_sh;
                end
                AOP_DIV, AOP_DIVQ:
                begin
                    y_next = ge ? 64'(rr - {1'b0, z_reg}) : rr[63:0];
                    x_next = {x_reg[127:80], x_reg[78:0], ge};
                end
                default:
                begin
                    if (y_reg >= tsum)
                    begin
                        y_next = y_reg - tsum;
                        x_next = {64'b0, (x_reg[63:0] >> 1) + z_reg};
                    end
                    else
                    begin
                        x_next = {64'b0, x_reg[63:0] >> 1};
                    end
                    z_next = z_reg >> 2;
                end
            endcase
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign prod_sh = x_reg >> sh_reg;

    always_comb
    begin
        rsp.done = done_reg;
        case (op_reg)
            AOP_MUL:
            begin
                rsp.res = prod_sh[63:0];
                rsp.big = |prod_sh[127:63];
            end
            AOP_DIV, AOP_DIVQ:
            begin
                rsp.res = x_reg[63:0];
                rsp.big = |x_reg[79:63];
            end
            default:
            begin
                rsp.res = x_reg[63:0];
                rsp.big = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/running_four_moments.sv -----
// running_four_moments: streaming count, mean, variance, skewness and kurtosis
// top level: step sequencer, moment accumulators and result register;
// uses rfm_pkg and the shared arithmetic unit rfm_arith
//
// Takes one signed Q8.8 sample per beat and returns one result beat per sample
// with the saturating count, the Q8.16 mean, the Q16.16 sample variance, Q8.16
// skewness and excess kurtosis, and a sticky overflow flag. All arithmetic runs
// on one shared unit, one operation at a time. Each sample runs the mean and
// moment update steps; with two samples the variance divide is added, from
// three samples on, with a positive spread, the square root and skewness
// steps, and from four on the kurtosis steps; the one-bit-per-cycle divider
// sets most of the time. The sample side is stalled while a sample is worked
// on; a finished result waits in an output register, so the next sample is
// taken while it is still unread.
module running_four_moments
    import rfm_pkg::*;
#(
    parameter int COUNT_BITS    = 24,
    parameter int ACC_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic signed [15:0]  sample,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [23:0]         sample_count,
    output logic signed [23:0]  running_mean,
    output logic [31:0]         sample_variance,
    output logic signed [23:0]  skewness,
    output logic signed [23:0]  excess_kurtosis,
    output logic                overflow_seen
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [6:0] SH0  = 7'd0;
    localparam logic [6:0] SH40 = 7'd40;
    localparam logic [6:0] SHT  = 7'(40 - ACC_FRAC_BITS);
    localparam logic [6:0] SHX  = 7'(ACC_FRAC_BITS + 8);
    localparam logic [6:0] SHY  = 7'(72 - ACC_FRAC_BITS);
    localparam logic [6:0] SHA3 = 7'(80 - ACC_FRAC_BITS);
    localparam logic [6:0] SHF  = 7'(ACC_FRAC_BITS);
    localparam int VSHR = (ACC_FRAC_BITS >= 16) ? ACC_FRAC_BITS - 16 : 0;
    localparam int VSHL = (ACC_FRAC_BITS < 16) ? 16 - ACC_FRAC_BITS : 0;
    localparam logic signed [63:0] MEAN_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MEAN_LO = -64'sh0000_8000_0000_0000;
    localparam logic signed [63:0] R24_HI  = 64'sd8388607;
    localparam logic signed [63:0] R24_LO  = -64'sd8388608;
    localparam logic signed [63:0] KURT_OFS = -64'sd196608;

    function automatic sat64_t sadd(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        sat64_t r;
        s = {a[63], a} + {b[63], b};
        r.sat = s[64] ^ s[63];
        r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    step_t                   step_reg, step_next;
    logic                    wait_reg, wait_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]   cnew_reg, cnew_next;
    logic [COUNT_BITS-1:0]   cold_reg, cold_next;
    logic signed [47:0]      mean_reg, mean_next;
    logic signed [63:0]      m2_reg, m2_next;
    logic signed [63:0]      m3_reg, m3_next;
    logic signed [63:0]      m4_reg, m4_next;
    logic                    sat_reg, sat_next;

    logic signed [63:0]      dlt_reg, dlt_next;
    logic signed [63:0]      dk_reg, dk_next;
    logic signed [63:0]      tmp_reg, tmp_next;
    logic signed [63:0]      t40_reg, t40_next;
    logic signed [63:0]      termf_reg, termf_next;
    logic [63:0]             poly_reg, poly_next;
    logic signed [63:0]      rr_reg, rr_next;
    logic signed [63:0]      ss_reg, ss_next;
    logic signed [63:0]      a4_reg, a4_next;
    logic signed [63:0]      b4_reg, b4_next;
    logic signed [63:0]      c4_reg, c4_next;
    logic signed [63:0]      a3_reg, a3_next;
    logic signed [63:0]      b3_reg, b3_next;
    logic signed [63:0]      pv_reg, pv_next;
    logic signed [63:0]      sd_reg, sd_next;
    logic signed [63:0]      den3_reg, den3_next;
    logic signed [63:0]      den4_reg, den4_next;
    logic [31:0]             var_reg, var_next;
    logic signed [23:0]      skew_reg, skew_next;
    logic signed [23:0]      kurt_reg, kurt_next;

    logic                    ov_reg, ov_next;
    logic [23:0]             ocount_reg, ocount_next;
    logic signed [23:0]      omean_reg, omean_next;
    logic [31:0]             ovar_reg, ovar_next;
    logic signed [23:0]      oskew_reg, oskew_next;
    logic signed [23:0]      okurt_reg, okurt_next;
    logic                    oflag_reg, oflag_next;

    // operand selection for the shared unit
    logic                    use_unit;
    arith_op_t               op_sel;
    logic signed [63:0]      a_s, b_s;
    logic                    b_uns;
    logic [6:0]              sh_sel;
    logic                    start;
    arith_req_t              areq;
    arith_rsp_t              arsp;

    logic [63:0]             cn64;
    logic                    neg;
    logic                    big_eff;
    logic signed [63:0]      sres;
    logic signed [63:0]      mean_sum;
    logic signed [63:0]      vpos;
    logic [71:0]             vscaled;
    logic [87:0]             pv_wide;
    logic signed [63:0]      sqrt_in;
    sat64_t                  s4a, s3a, s2a, s4b, s3b, s4c, kofs;
    logic [32:0]             cnt_wide;
    logic signed [47:0]      mean_adj;
    logic                    in_take;

    assign cn64 = 64'(cnew_reg);

    assign pv_wide = {24'b0, pv_reg} << ACC_FRAC_BITS;
    assign sqrt_in = (|pv_wide[87:63]) ? S64_MAX : pv_wide[63:0];

    always_comb
    begin
        use_unit = 1'b1;
        op_sel   = AOP_MUL;
        a_s      = '0;
        b_s      = '0;
        b_uns    = 1'b0;
        sh_sel   = SH0;
        case (step_reg)
            ST_DK:   begin op_sel = AOP_DIV; a_s = dlt_reg; b_s = cn64; b_uns = 1'b1; end
            ST_M1:   begin a_s = dlt_reg; b_s = dk_reg; sh_sel = SH40; end
            ST_T40:  begin a_s = tmp_reg; b_s = 64'(cold_reg); b_uns = 1'b1; end
            ST_TERM: begin a_s = t40_reg; b_s = 64'sd1; sh_sel = SHT; end
            ST_POLY: begin a_s = cn64; b_s = cn64; b_uns = 1'b1; end
            ST_RR:   begin a_s = dk_reg; b_s = poly_reg; b_uns = 1'b1; sh_sel = SHT; end
            ST_SS:   begin a_s = rr_reg; b_s = dk_reg; sh_sel = SH40; end
            ST_A4:   begin a_s = t40_reg; b_s = ss_reg; sh_sel = SH40; end
            ST_X:    begin a_s = m2_reg; b_s = dk_reg; sh_sel = SHX; end
            ST_Y:    begin a_s = tmp_reg; b_s = dk_reg; sh_sel = SHY; end
            ST_B4:   begin a_s = tmp_reg; b_s = 64'sd6; end
            ST_Z:    begin a_s = m3_reg; b_s = dk_reg; sh_sel = SH40; end
            ST_C4:   begin a_s = tmp_reg; b_s = 64'sd4; end
            ST_W:    begin a_s = dk_reg; b_s = cn64 - 64'd2; end
            ST_A3:   begin a_s = t40_reg; b_s = tmp_reg; sh_sel = SHA3; end
            ST_U:    begin a_s = m2_reg; b_s = dk_reg; sh_sel = SH40; end
            ST_B3:   begin a_s = tmp_reg; b_s = 64'sd3; end
            ST_VAR:  begin op_sel = AOP_DIV; a_s = m2_reg; b_s = cn64 - 64'd1; b_uns = 1'b1; end
            ST_PV:   begin op_sel = AOP_DIV; a_s = m2_reg; b_s = cn64; b_uns = 1'b1; end
            ST_SQRT: begin op_sel = AOP_SQRT; a_s = sqrt_in; b_uns = 1'b1; end
            ST_DEN3: begin a_s = pv_reg; b_s = sd_reg; sh_sel = SHF; end
            ST_DEN4: begin a_s = pv_reg; b_s = pv_reg; sh_sel = SHF; end
            ST_N3:   begin op_sel = AOP_DIV; a_s = m3_reg; b_s = cn64; b_uns = 1'b1; end
            ST_SKEW: begin op_sel = AOP_DIVQ; a_s = tmp_reg; b_s = den3_reg; b_uns = 1'b1; end
            ST_N4:   begin op_sel = AOP_DIV; a_s = m4_reg; b_s = cn64; b_uns = 1'b1; end
            ST_KURT: begin op_sel = AOP_DIVQ; a_s = tmp_reg; b_s = den4_reg; b_uns = 1'b1; end
            default: use_unit = 1'b0;
        endcase
    end

    assign start   = use_unit && !wait_reg;
    assign areq.op = op_sel;
    assign areq.a  = mag(a_s);
    assign areq.b  = b_uns ? 64'(b_s) : mag(b_s);
    assign areq.sh = sh_sel;

    rfm_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (areq),
        .rsp   (arsp)
    );

    // sign and saturation of the unit result
    assign neg     = a_s[63] ^ (!b_uns && b_s[63]);
    assign big_eff = arsp.big && (op_sel == AOP_MUL || op_sel == AOP_DIVQ);
    assign sres    = big_eff ? (neg ? -S64_MAX : S64_MAX)
                             : (neg ? -$signed(arsp.res) : $signed(arsp.res));

    assign mean_sum = {{16{mean_reg[47]}}, mean_reg} + sres;
    assign vpos     = sres[63] ? 64'sd0 : sres;
    assign vscaled  = ({8'b0, vpos} >> VSHR) << VSHL;

    assign s4a  = sadd(m4_reg, a4_reg);
    assign s3a  = sadd(m3_reg, a3_reg);
    assign s2a  = sadd(m2_reg, termf_reg);
    assign s4b  = sadd(m4_reg, b4_reg);
    assign s3b  = sadd(m3_reg, -b3_reg);
    assign s4c  = sadd(m4_reg, -c4_reg);
    assign kofs = sadd(sres, KURT_OFS);

    assign in_take      = sample_valid && !sample_stall;
    assign sample_stall = (step_reg != ST_IDLE);

    assign cnt_wide = 33'(cnt_reg);
    assign mean_adj = mean_reg + (mean_reg[47] ? 48'sh00_0000_FF_FFFF : 48'sd0);

    always_comb
    begin
        step_next  = step_reg;
        wait_next  = wait_reg;
        cnt_next   = cnt_reg;
        cnew_next  = cnew_reg;
        cold_next  = cold_reg;
        mean_next  = mean_reg;
        m2_next    = m2_reg;
        m3_next    = m3_reg;
        m4_next    = m4_reg;
        sat_next   = sat_reg;
        dlt_next   = dlt_reg;
        dk_next    = dk_reg;
        tmp_next   = tmp_reg;
        t40_next   = t40_reg;
        termf_next = termf_reg;
        poly_next  = poly_reg;
        rr_next    = rr_reg;
        ss_next    = ss_reg;
        a4_next    = a4_reg;
        b4_next    = b4_reg;
        c4_next    = c4_reg;
        a3_next    = a3_reg;
        b3_next    = b3_reg;
        pv_next    = pv_reg;
        sd_next    = sd_reg;
        den3_next  = den3_reg;
        den4_next  = den4_reg;
        var_next   = var_reg;
        skew_next  = skew_reg;
        kurt_next  = kurt_reg;
        ov_next     = ov_reg;
        ocount_next = ocount_reg;
        omean_next  = omean_reg;
        ovar_next   = ovar_reg;
        oskew_next  = oskew_reg;
        okurt_next  = okurt_reg;
        oflag_next  = oflag_reg;

        if (ov_reg && !result_stall)
        begin
            ov_next = 1'b0;
        end

        if (start)
        begin
            wait_next = 1'b1;
        end

        // unit result comes back
        if (wait_reg && arsp.done)
        begin
            wait_next = 1'b0;
            if (big_eff && step_reg != ST_POLY)
            begin
                sat_next = 1'b1;
            end
        end

        case (step_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (cnt_reg == CNT_MAX)
                    begin
                        sat_next  = 1'b1;
                        cnew_next = CNT_MAX;
                        cold_next = CNT_MAX - 1'b1;
                    end
                    else
                    begin
                        cnew_next = cnt_reg + 1'b1;
                        cold_next = cnt_reg;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    dlt_next  = {{16{sample[15]}}, sample, 32'b0}
                              - {{16{mean_reg[47]}}, mean_reg};
                    var_next  = '0;
                    skew_next = '0;
                    kurt_next = '0;
                    step_next = ST_DK;
                end
            end
            ST_SUM1:
            begin
                m4_next   = s4a.val;
                m3_next   = s3a.val;
                m2_next   = s2a.val;
                sat_next  = sat_reg | s4a.sat | s3a.sat | s2a.sat;
                step_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                m4_next   = s4b.val;
                m3_next   = s3b.val;
                sat_next  = sat_reg | s4b.sat | s3b.sat;
                step_next = ST_SUM3;
            end
            ST_SUM3:
            begin
                m4_next   = s4c.val;
                sat_next  = sat_reg | s4c.sat;
                step_next = (cn64 >= 64'd2) ? ST_VAR : ST_FIN;
            end
            ST_FIN:
            begin
                if (!ov_reg || !result_stall)
                begin
                    ov_next     = 1'b1;
                    ocount_next = (cnt_wide > 33'h0_00FF_FFFF) ? 24'hFF_FFFF : cnt_wide[23:0];
                    omean_next  = mean_adj[47:24];
                    ovar_next   = var_reg;
                    oskew_next  = skew_reg;
                    okurt_next  = kurt_reg;
                    oflag_next  = sat_reg;
                    step_next   = ST_IDLE;
                end
            end
            default:
            begin
                if (wait_reg && arsp.done)
                begin
                    case (step_reg)
                        ST_DK:
                        begin
                            dk_next = sres;
                            if (mean_sum > MEAN_HI)
                            begin
                                mean_next = MEAN_HI[47:0];
                                sat_next  = 1'b1;
                            end
                            else if (mean_sum < MEAN_LO)
                            begin
                                mean_next = MEAN_LO[47:0];
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                mean_next = mean_sum[47:0];
                            end
                            step_next = ST_M1;
                        end
                        ST_M1:   begin tmp_next = sres; step_next = ST_T40; end
                        ST_T40:  begin t40_next = sres; step_next = ST_TERM; end
                        ST_TERM: begin termf_next = sres; step_next = ST_POLY; end
                        ST_POLY:
                        begin
                            poly_next = arsp.res - (cn64 + (cn64 << 1)) + 64'd3;
                            step_next = ST_RR;
                        end
                        ST_RR:   begin rr_next = sres; step_next = ST_SS; end
                        ST_SS:   begin ss_next = sres; step_next = ST_A4; end
                        ST_A4:   begin a4_next = sres; step_next = ST_X; end
                        ST_X:    begin tmp_next = sres; step_next = ST_Y; end
                        ST_Y:    begin tmp_next = sres; step_next = ST_B4; end
                        ST_B4:   begin b4_next = sres; step_next = ST_Z; end
                        ST_Z:    begin tmp_next = sres; step_next = ST_C4; end
                        ST_C4:   begin c4_next = sres; step_next = ST_W; end
                        ST_W:    begin tmp_next = sres; step_next = ST_A3; end
                        ST_A3:   begin a3_next = sres; step_next = ST_U; end
                        ST_U:    begin tmp_next = sres; step_next = ST_B3; end
                        ST_B3:   begin b3_next = sres; step_next = ST_SUM1; end
                        ST_VAR:
                        begin
                            if (|vscaled[71:32])
                            begin
                                var_next = 32'hFFFF_FFFF;
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                var_next = vscaled[31:0];
                            end
                            step_next = (cn64 >= 64'd3 && m2_reg > 64'sd0) ? ST_PV : ST_FIN;
                        end
                        ST_PV:   begin pv_next = sres; step_next = ST_SQRT; end
                        ST_SQRT:
                        begin
                            sd_next = sres;
                            if (|pv_wide[87:63])
                            begin
                                sat_next = 1'b1;
                            end
                            step_next = ST_DEN3;
                        end
                        ST_DEN3: begin den3_next = sres; step_next = ST_DEN4; end
                        ST_DEN4: begin den4_next = sres; step_next = ST_N3; end
                        ST_N3:
                        begin
                            tmp_next = sres;
                            if (den3_reg > 64'sd0)
                                step_next = ST_SKEW;
                            else if (cn64 >= 64'd4 && den4_reg > 64'sd0)
                                step_next = ST_N4;
                            else
                                step_next = ST_FIN;
                        end
                        ST_SKEW:
                        begin
                            if (sres > R24_HI)
                            begin
                                skew_next = R24_HI[23:0];
                                sat_next  = 1'b1;
                            end
                            else if (sres < R24_LO)
                            begin
                                skew_next = R24_LO[23:0];
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                skew_next = sres[23:0];
                            end
                            step_next = (cn64 >= 64'd4 && den4_reg > 64'sd0) ? ST_N4 : ST_FIN;
                        end
                        ST_N4:   begin tmp_next = sres; step_next = ST_KURT; end
                        ST_KURT:
                        begin
                            if (kofs.sat)
                            begin
                                sat_next = 1'b1;
                            end
                            if (kofs.val > R24_HI)
                            begin
                                kurt_next = R24_HI[23:0];
                                sat_next  = 1'b1;
                            end
                            else if (kofs.val < R24_LO)
                            begin
                                kurt_next = R24_LO[23:0];
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                kurt_next = kofs.val[23:0];
                            end
                            step_next = ST_FIN;
                        end
                        default: step_next = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            wait_reg <= 1'b0;
            cnt_reg  <= '0;
            mean_reg <= '0;
            m2_reg   <= '0;
            m3_reg   <= '0;
            m4_reg   <= '0;
            sat_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            wait_reg <= wait_next;
            cnt_reg  <= cnt_next;
            mean_reg <= mean_next;
            m2_reg   <= m2_next;
            m3_reg   <= m3_next;
            m4_reg   <= m4_next;
            sat_reg  <= sat_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnew_reg   <= cnew_next;
        cold_reg   <= cold_next;
        dlt_reg    <= dlt_next;
        dk_reg     <= dk_next;
        tmp_reg    <= tmp_next;
        t40_reg    <= t40_next;
        termf_reg  <= termf_next;
        poly_reg   <= poly_next;
        rr_reg     <= rr_next;
        ss_reg     <= ss_next;
        a4_reg     <= a4_next;
        b4_reg     <= b4_next;
        c4_reg     <= c4_next;
        a3_reg     <= a3_next;
        b3_reg     <= b3_next;
        pv_reg     <= pv_next;
        sd_reg     <= sd_next;
        den3_reg   <= den3_next;
        den4_reg   <= den4_next;
        var_reg    <= var_next;
        skew_reg   <= skew_next;
        kurt_reg   <= kurt_next;
        ocount_reg <= ocount_next;
        omean_reg  <= omean_next;
        ovar_reg   <= ovar_next;
        oskew_reg  <= oskew_next;
        okurt_reg  <= okurt_next;
        oflag_reg  <= oflag_next;
    end

    assign result_valid    = ov_reg;
    assign sample_count    = ocount_reg;
    assign running_mean    = omean_reg;
    assign sample_variance = ovar_reg;
    assign skewness        = oskew_reg;
    assign excess_kurtosis = okurt_reg;
    assign overflow_seen   = oflag_reg;

endmodule

// ----- tb/sv/running_four_moments_tb.sv -----
// running_four_moments_tb: self-checking bench for the streaming moments engine
// drives signed Q8.8 samples with random gaps, predicts every result beat with a
// bit-exact fixed-point Welford model and checks it; depends on rfm_pkg and the rtl
module running_four_moments_tb
    import rfm_pkg::*;
();

    localparam int     N_RANDOM  = 550;
    localparam longint CNT_LIMIT = (longint'(1) <<< 24) - 1;
    localparam longint LO24      = -(longint'(1) <<< 23);
    localparam longint HI24      = (longint'(1) <<< 23) - 1;

    typedef struct packed {
        logic [23:0]        cnt;
        logic signed [23:0] mean;
        logic [31:0]        var_q;
        logic signed [23:0] skew;
        logic signed [23:0] kurt;
        logic               ovf;
    } stats_t;

    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_stall;
    logic signed [15:0] sample;
    logic               result_valid;
    logic               result_stall;
    logic [23:0]        sample_count;
    logic signed [23:0] running_mean;
    logic [31:0]        sample_variance;
    logic signed [23:0] skewness;
    logic signed [23:0] excess_kurtosis;
    logic               overflow_seen;

    logic signed [15:0] pending_samples[$];
    stats_t             expected_stats[$];
    int                 n_taken;
    int                 n_checked;
    int                 n_errors;
    int                 n_total;
    int                 send_gap;
    int                 recv_gap;
    int                 hold_left;
    bit                 hold_done;

    // model state
    longint cnt_q, mean_q, m2_q, m3_q, m4_q;
    bit     sat_q;

    running_four_moments i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .sample_count    (sample_count),
        .running_mean    (running_mean),
        .sample_variance (sample_variance),
        .skewness        (skewness),
        .excess_kurtosis (excess_kurtosis),
        .overflow_seen   (overflow_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic queue_sample(input logic signed [15:0] v);
        pending_samples = {pending_samples, v};
    endtask

    task automatic queue_expected(input stats_t s);
        expected_stats = {expected_stats, s};
    endtask

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // magnitude back to signed, clamped symmetrically
    function automatic longint to_signed(logic [63:0] m, bit neg, bit big);
        if (big || m[63])
        begin
            sat_q = 1'b1;
            return neg ? -S64_MAX : S64_MAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_su(longint a, logic [63:0] b, int sh);
        logic [127:0] prod;
        prod = ({64'd0, mag64(a)} * {64'd0, b}) >> sh;
        return to_signed(prod[63:0], a < 0, |prod[127:63]);
    endfunction

    function automatic longint mul_s(longint a, longint b, int sh);
        logic [127:0] prod;
        prod = ({64'd0, mag64(a)} * {64'd0, mag64(b)}) >> sh;
        return to_signed(prod[63:0], (a < 0) != (b < 0), |prod[127:63]);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        if (b > 0 && a > S64_MAX - b)
        begin
            sat_q = 1'b1;
            return S64_MAX;
        end
        if (b < 0 && a < S64_MIN - b)
        begin
            sat_q = 1'b1;
            return S64_MIN;
        end
        return a + b;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi)
        begin
            sat_q = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            sat_q = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // num * 2^16 / den, truncated toward zero
    function automatic longint frac_div(longint num, logic [63:0] den);
        logic [63:0]  m;
        logic [127:0] q;
        m = mag64(num);
        if (m / den >= (64'd1 << 47))
            return to_signed(0, num < 0, 1'b1);
        q = ({64'd0, m} << 16) / {64'd0, den};
        return to_signed(q[63:0], num < 0, 1'b0);
    endfunction

    function automatic stats_t advance_moments(logic signed [15:0] x);
        longint cold, cnew, dlt, dk, t40, termf, poly, rr, ss, a4, b4, c4, a3, b3;
        longint m2_old, m3_old, vv, pv, sd, den3, den4;
        stats_t s;
        s = '0;
        m2_old = m2_q;
        m3_old = m3_q;
        if (cnt_q >= CNT_LIMIT)
        begin
            sat_q = 1'b1;
            cnew = CNT_LIMIT;
            cold = CNT_LIMIT - 1;
        end
        else
        begin
            cold = cnt_q;
            cnew = cnt_q + 1;
        end
        cnt_q = cnew;

        dlt = longint'(x) * 64'sd4294967296 - mean_q;
        dk = dlt / cnew;
        mean_q = clamp(mean_q + dk, -(longint'(1) <<< 47), (longint'(1) <<< 47) - 1);

        t40 = mul_su(mul_s(dlt, dk, 40), 64'(cold), 0);
        termf = mul_s(t40, 1, 24);

        poly = cnew * cnew - 3 * cnew + 3;
        rr = mul_su(dk, 64'(poly), 24);
        ss = mul_s(rr, dk, 40);
        a4 = mul_s(t40, ss, 40);
        b4 = mul_s(mul_s(mul_s(m2_old, dk, 24), dk, 56), 6, 0);
        c4 = mul_s(mul_s(m3_old, dk, 40), 4, 0);
        m4_q = sat_add(sat_add(sat_add(m4_q, a4), b4), -c4);

        a3 = mul_s(t40, mul_s(dk, cnew - 2, 0), 64);
        b3 = mul_s(mul_s(m2_old, dk, 40), 3, 0);
        m3_q = sat_add(sat_add(m3_q, a3), -b3);
        m2_q = sat_add(m2_q, termf);

        s.mean = 24'(mean_q / 64'sd16777216);
        if (cnew >= 2)
        begin
            vv = m2_q / (cnew - 1);
            if (vv < 0) vv = 0;
            s.var_q = 32'(clamp(vv, 0, 64'sd4294967295));
        end
        if (cnew >= 3 && m2_q > 0)
        begin
            pv = m2_q / cnew;
            sd = longint'(floor_sqrt(64'(mul_s(pv, 65536, 0))));
            den3 = mul_s(pv, sd, 16);
            den4 = mul_s(pv, pv, 16);
            if (den3 > 0)
                s.skew = 24'(clamp(frac_div(m3_q / cnew, 64'(den3)), LO24, HI24));
            if (cnew >= 4 && den4 > 0)
                s.kurt = 24'(clamp(sat_add(frac_div(m4_q / cnew, 64'(den4)),
                                           -(longint'(3) <<< 16)), LO24, HI24));
        end
        s.cnt = cnt_q > 64'sd16777215 ? 24'hFFFFFF : 24'(cnt_q);
        s.ovf = sat_q;
        return s;
    endfunction

    // sample side: gap drawn per beat, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            send_gap     = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                queue_expected(advance_moments(sample));
                n_taken++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample       <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    send_gap     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // result side: checks each beat, draws a stall per beat, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        stats_t got;
        stats_t exp_s;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_gap     = 0;
            hold_left    = 0;
            hold_done    = 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got = '{sample_count, running_mean, sample_variance, skewness,
                        excess_kurtosis, overflow_seen};
                n_checked++;
                recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                if (expected_stats.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result beat %p", $time, got);
                end
                else
                begin
                    exp_s = expected_stats.pop_front();
                    if (got.cnt !== exp_s.cnt)
                        $display("%0t: count exp %0d got %0d", $time, exp_s.cnt, got.cnt);
                    if (got.mean !== exp_s.mean)
                        $display("%0t: mean exp %0d got %0d", $time, exp_s.mean, got.mean);
                    if (got.var_q !== exp_s.var_q)
                        $display("%0t: variance exp %0d got %0d", $time, exp_s.var_q,
                                 got.var_q);
                    if (got.skew !== exp_s.skew)
                        $display("%0t: skewness exp %0d got %0d", $time, exp_s.skew, got.skew);
                    if (got.kurt !== exp_s.kurt)
                        $display("%0t: kurtosis exp %0d got %0d", $time, exp_s.kurt, got.kurt);
                    if (got.ovf !== exp_s.ovf)
                        $display("%0t: overflow exp %0d got %0d", $time, exp_s.ovf, got.ovf);
                    if (got !== exp_s)
                        n_errors++;
                end
                if (n_checked == 120 && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = 4000;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        logic signed [15:0] base;
        int                 spread;
        n_taken   = 0;
        n_checked = 0;
        n_errors  = 0;
        cnt_q  = 0;
        mean_q = 0;
        m2_q   = 0;
        m3_q   = 0;
        m4_q   = 0;
        sat_q  = 1'b0;
        rst_n  = 1'b0;

        // zero spread through the first five samples, then spread appears
        repeat (5) queue_sample(16'sd256);
        queue_sample(16'sd0);
        queue_sample(-16'sd1);
        queue_sample(16'sd1);
        queue_sample(16'sd100);
        // field extremes, likely to saturate the higher sums
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh5555);
        queue_sample(16'shAAAA);
        queue_sample(16'sh0000);
        queue_sample(16'shFFFF);
        // random part: mostly clustered around a drifting center, some full range
        base = 16'($urandom);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 60 == 0) base = 16'($urandom);
            spread = $urandom_range(0, 2) == 0 ? 4096 : 256;
            if ($urandom_range(0, 4) == 0)
                queue_sample(16'($urandom));
            else
                queue_sample(base + 16'($urandom_range(0, spread)) - 16'(spread / 2));
        end
        n_total = pending_samples.size();

        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        wait (n_taken == n_total && expected_stats.size() == 0);
        repeat (1000) @(posedge clk);
        $display("checked %0d result beats from %0d samples: zero spread, extremes,",
                 n_checked, n_taken);
        $display("clustered and full-range data, with random gaps and a long output hold");
        if (n_errors == 0 && expected_stats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("timeout after %0d of %0d samples", n_taken, n_total);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rfm_pkg.sv
src/rfm_arith.sv
src/running_four_moments.sv
tb/sv/running_four_moments_tb.sv
